// ===== rtl/core/bsce_pkg.sv =====
// ----------------------------------------------------------------------------
// bsce_pkg: shared definitions for the bit-serial cell
// Field widths, flag constants and elaboration-time helpers.
// ----------------------------------------------------------------------------
package bsce_pkg;

  localparam int MEM_BITS_DEF = 4096;
  localparam int ADDR_W       = 12;
  localparam int ADDR_SPAN    = 1 << ADDR_W;
  localparam int FLAG_W       = 4;
  localparam int FLAG_N       = 16;
  localparam int TAB_W        = 8;

  // read-only flags 0, 3, 4, 6 and 7
  localparam logic [FLAG_N-1:0] RO_FLAGS = 16'b0000_0000_1101_1001;

  // steps of the shift-subtract address wrap: shifts j with (m << j) below the span
  function automatic int red_steps(input int m);
    int n;
    n = 0;
    for (int i = 0; i <= ADDR_W; i++) begin
      if ((m << i) < ADDR_SPAN) n = i + 1;
    end
    return n;
  endfunction

  function automatic logic flag_ro(input logic [FLAG_W-1:0] n);
    return RO_FLAGS[n];
  endfunction

endpackage

// ===== rtl/core/bsce_in_if.sv =====
// ----------------------------------------------------------------------------
// bsce_in_if: instruction channel
// Valid/ready channel carrying one cell instruction per transfer.
// ----------------------------------------------------------------------------
interface bsce_in_if
  import bsce_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [FLAG_W-1:0] read_flag;
  logic [FLAG_W-1:0] write_flag;
  logic [FLAG_W-1:0] cond_flag;
  logic              cond_sense;
  logic [TAB_W-1:0]  mem_table;
  logic [TAB_W-1:0]  flag_table;

  modport source (
    output valid, addr_a, addr_b, read_flag, write_flag, cond_flag, cond_sense,
           mem_table, flag_table,
    input  ready
  );

  modport sink (
    input  valid, addr_a, addr_b, read_flag, write_flag, cond_flag, cond_sense,
           mem_table, flag_table,
    output ready
  );
endinterface

// ===== rtl/core/bsce_out_if.sv =====
// ----------------------------------------------------------------------------
// bsce_out_if: result channel
// Valid/ready channel carrying one flag result per transfer.
// ----------------------------------------------------------------------------
interface bsce_out_if
  import bsce_pkg::*;
();
  logic valid;
  logic ready;
  logic flag_result;

  modport source (
    output valid, flag_result,
    input  ready
  );

  modport sink (
    input  valid, flag_result,
    output ready
  );
endinterface

// ===== rtl/core/bsce_ram.sv =====
// ----------------------------------------------------------------------------
// bsce_ram: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsce_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bit_serial_cell_execute.sv =====
// ----------------------------------------------------------------------------
// bit_serial_cell_execute: one cell of a bit-serial SIMD array
// Executes truth-table instructions on a one-bit cell memory and 16 flags.
//
//   channel | dir | payload                                          | port
//   --------+-----+--------------------------------------------------+------
//   in_i    | in  | addr_a addr_b read_flag write_flag cond_flag     | sink
//           |     | cond_sense mem_table flag_table                  |
//   out_o   | out | flag_result                                      | source
//
// Steps: accept, read A, read B, execute for an executed instruction; accept
//   and output for a skipped one (the cell memory has a single read port).
//   When MEM_BITS is below 4096 and not a power of two, each address takes
//   RED_STEPS wrap steps in one shared compare-subtract unit, a step a cycle.
// Reset: a clearing pass writes zero to the cell memory, with in_i.ready low
//   throughout.
// Stalls: the result waits in the output register; a new instruction is taken
//   meanwhile, and the cell holds in its last step while that register is full.
// ----------------------------------------------------------------------------
module bit_serial_cell_execute
  import bsce_pkg::*;
#(
  parameter int MEM_BITS = MEM_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bsce_in_if.sink    in_i,
  bsce_out_if.source out_o
);

  localparam int AW        = (MEM_BITS > 1) ? $clog2(MEM_BITS) : 1;
  localparam bit WRAP_FREE = (MEM_BITS >= ADDR_SPAN) || ((MEM_BITS & (MEM_BITS - 1)) == 0);
  localparam int RED_STEPS = red_steps(MEM_BITS);
  localparam int SW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam logic [SW-1:0] STEP_TOP = SW'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BITS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RED   = 3'd2;
  localparam logic [2:0] ST_RDA   = 3'd3;
  localparam logic [2:0] ST_RDB   = 3'd4;
  localparam logic [2:0] ST_EXEC  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [SW-1:0]     step_q, step_d;
  logic              sel_b_q, sel_b_d;
  logic [FLAG_N-1:0] flags_q, flags_d;
  logic              out_valid_q, out_valid_d;
  logic              out_flag_q, out_flag_d;

  logic [ADDR_W-1:0] a_q, a_d;
  logic [ADDR_W-1:0] b_q, b_d;
  logic [FLAG_W-1:0] rflag_q, rflag_d;
  logic [FLAG_W-1:0] wflag_q, wflag_d;
  logic [TAB_W-1:0]  mtab_q, mtab_d;
  logic [TAB_W-1:0]  ftab_q, ftab_d;
  logic              va_q, va_d;
  logic              res_q, res_d;

  logic                  in_xfer;
  logic                  out_free;
  logic                  cond_ok;
  logic [ADDR_W-1:0]     red_opnd;
  logic [2*ADDR_W-1:0]   red_sub;
  logic                  red_ge;
  logic [ADDR_W-1:0]     red_res;
  logic [2:0]            tab_idx;
  logic                  mem_val;
  logic                  flag_val;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  bsce_ram #(
    .WIDTH (1),
    .DEPTH (MEM_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready        = (state_q == ST_IDLE);
  assign in_xfer           = in_i.valid && in_i.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.flag_result = out_flag_q;
  assign out_free          = !out_valid_q || out_o.ready;
  assign cond_ok           = (flags_q[in_i.cond_flag] == in_i.cond_sense);

  assign red_opnd = sel_b_q ? b_q : a_q;
  assign red_sub  = (2 * ADDR_W)'(MEM_BITS) << step_q;
  assign red_ge   = {{ADDR_W{1'b0}}, red_opnd} >= red_sub;
  assign red_res  = red_opnd - red_sub[ADDR_W-1:0];

  assign tab_idx  = {va_q, ram_rdata, flags_q[rflag_q]};
  assign mem_val  = mtab_q[~tab_idx];
  assign flag_val = ftab_q[~tab_idx];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    step_d      = step_q;
    sel_b_d     = sel_b_q;
    flags_d     = flags_q;
    out_valid_d = out_valid_q;
    out_flag_d  = out_flag_q;
    a_d         = a_q;
    b_d         = b_q;
    rflag_d     = rflag_q;
    wflag_d     = wflag_q;
    mtab_d      = mtab_q;
    ftab_d      = ftab_q;
    va_d        = va_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(a_q);
    ram_wdata   = mem_val;
    ram_re      = 1'b0;
    ram_raddr   = AW'(a_q);

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          a_d     = in_i.addr_a;
          b_d     = in_i.addr_b;
          rflag_d = in_i.read_flag;
          wflag_d = in_i.write_flag;
          mtab_d  = in_i.mem_table;
          ftab_d  = in_i.flag_table;
          sel_b_d = 1'b0;
          step_d  = STEP_TOP;
          if (!cond_ok) begin
            res_d   = 1'b0;
            state_d = ST_OUT;
          end else if (WRAP_FREE) begin
            state_d = ST_RDA;
          end else begin
            state_d = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (red_ge) begin
          if (sel_b_q) b_d = red_res;
          else         a_d = red_res;
        end
        step_d = step_q - SW'(1);
        if (step_q == '0) begin
          step_d = STEP_TOP;
          if (sel_b_q) state_d = ST_RDA;
          else         sel_b_d = 1'b1;
        end
      end
      ST_RDA: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(a_q);
        state_d   = ST_RDB;
      end
      ST_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(b_q);
        va_d      = ram_rdata;
        state_d   = ST_EXEC;
      end
      ST_EXEC: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(a_q);
        ram_wdata = mem_val;
        if (!flag_ro(wflag_q)) flags_d[wflag_q] = flag_val;
        res_d = flag_val;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_flag_d  = flag_val;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_flag_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      sel_b_q     <= 1'b0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      sel_b_q     <= sel_b_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_flag_q <= out_flag_d;
    a_q        <= a_d;
    b_q        <= b_d;
    rflag_q    <= rflag_d;
    wflag_q    <= wflag_d;
    mtab_q     <= mtab_d;
    ftab_q     <= ftab_d;
    va_q       <= va_d;
    res_q      <= res_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q & RO_FLAGS) == '0)
    else $error("read-only flag set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_EXEC))
    else $error("memory write outside clear or execute");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != ST_IDLE))
    else $error("instruction transfer did not start a sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_OUT))
    else $error("result raised outside its final step");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bit_serial_cell_execute
// Drives cell instructions through the instruction channel and checks every
// flag result against a cycle-free model of the cell memory and flags. The
// bench runs directed corner cases first, then three random phases with
// different idle mixes, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import bsce_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS    = 150;

  localparam logic [FLAG_N-1:0] READ_ONLY_MASK = 16'b0000_0000_1101_1001;
  localparam logic [FLAG_W-1:0] FLAG_ZERO      = 4'd0;
  localparam logic [FLAG_W-1:0] FLAG_LAST      = 4'd15;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [FLAG_W-1:0] read_flag;
    logic [FLAG_W-1:0] write_flag;
    logic [FLAG_W-1:0] cond_flag;
    logic              cond_sense;
    logic [TAB_W-1:0]  mem_table;
    logic [TAB_W-1:0]  flag_table;
  } cell_instr_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bsce_in_if  instr_if ();
  bsce_out_if result_if ();

  bit_serial_cell_execute DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (instr_if.sink),
    .out_o  (result_if.source)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  logic              cell_mem [MEM_BITS_DEF] = '{default: 1'b0};
  logic [FLAG_N-1:0] cell_flags = '0;

  cell_instr_t pending_instrs [$];
  logic        flag_expected [$];
  logic        exp_flag;

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;
  int holds_served;
  int hold_left;
  int mismatches    = 0;
  int cycle_count   = 0;

  function automatic logic cell_execute(input cell_instr_t ins);
    logic       va;
    logic       vb;
    logic       vf;
    logic [2:0] idx;
    logic       mv;
    logic       fv;
    if (cell_flags[ins.cond_flag] != ins.cond_sense) return 1'b0;
    va  = cell_mem[ins.addr_a];
    vb  = cell_mem[ins.addr_b];
    vf  = cell_flags[ins.read_flag];
    idx = {va, vb, vf};
    mv  = ins.mem_table[7 - idx];
    fv  = ins.flag_table[7 - idx];
    cell_mem[ins.addr_a] = mv;
    if (!READ_ONLY_MASK[ins.write_flag]) cell_flags[ins.write_flag] = fv;
    return fv;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_instr(input int a, input int b, input int rf, input int wf,
                             input int cf, input int cs, input int mt, input int ft);
    cell_instr_t ins;
    ins.addr_a     = ADDR_W'(a);
    ins.addr_b     = ADDR_W'(b);
    ins.read_flag  = FLAG_W'(rf);
    ins.write_flag = FLAG_W'(wf);
    ins.cond_flag  = FLAG_W'(cf);
    ins.cond_sense = 1'(cs);
    ins.mem_table  = TAB_W'(mt);
    ins.flag_table = TAB_W'(ft);
    pending_instrs.push_back(ins);
  endtask

  function automatic logic [ADDR_W-1:0] random_addr();
    if ($urandom_range(0, 3) == 0) return ADDR_W'($urandom_range(0, ADDR_SPAN - 1));
    return (($urandom_range(0, 1) != 0) ? 12'hFF0 : 12'h000) |
           ADDR_W'($urandom_range(0, 15));
  endfunction

  function automatic cell_instr_t random_instr();
    cell_instr_t ins;
    ins.addr_a     = random_addr();
    ins.addr_b     = ($urandom_range(0, 4) == 0) ? ins.addr_a : random_addr();
    ins.read_flag  = FLAG_W'($urandom_range(0, FLAG_N - 1));
    ins.write_flag = FLAG_W'($urandom_range(0, FLAG_N - 1));
    if ($urandom_range(0, 5) == 0) ins.cond_flag = FLAG_ZERO;
    else ins.cond_flag = FLAG_W'($urandom_range(0, FLAG_N - 1));
    ins.cond_sense = 1'($urandom_range(0, 1));
    ins.mem_table  = TAB_W'($urandom_range(0, 255));
    ins.flag_table = TAB_W'($urandom_range(0, 255));
    return ins;
  endfunction

  task automatic queue_random(input int count);
    repeat (count) pending_instrs.push_back(random_instr());
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_instrs.size() != 0 || instr_if.valid || flag_expected.size() != 0);
  endtask

  // instruction driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      instr_if.valid <= 1'b0;
      {instr_if.addr_a, instr_if.addr_b, instr_if.read_flag, instr_if.write_flag,
       instr_if.cond_flag, instr_if.cond_sense, instr_if.mem_table,
       instr_if.flag_table} <= '0;
    end else if (!instr_if.valid || instr_if.ready) begin
      if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        {instr_if.addr_a, instr_if.addr_b, instr_if.read_flag, instr_if.write_flag,
         instr_if.cond_flag, instr_if.cond_sense, instr_if.mem_table,
         instr_if.flag_table} <= pending_instrs.pop_front();
        instr_if.valid <= 1'b1;
      end else begin
        instr_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      holds_served    <= 0;
      hold_left       <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served    <= hold_requests;
      hold_left       <= RX_HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // transfer monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (instr_if.valid && instr_if.ready) begin
        flag_expected.push_back(cell_execute({instr_if.addr_a, instr_if.addr_b,
          instr_if.read_flag, instr_if.write_flag, instr_if.cond_flag,
          instr_if.cond_sense, instr_if.mem_table, instr_if.flag_table}));
      end
      if (result_if.valid && result_if.ready) begin
        if (flag_expected.size() == 0) begin
          report_mismatch("flag result with no instruction outstanding");
        end else begin
          exp_flag = flag_expected.pop_front();
          if (result_if.flag_result !== exp_flag)
            report_mismatch($sformatf("flag_result got %b expected %b",
                                      result_if.flag_result, exp_flag));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // skipped on flag zero, then address extremes and shared A/B address
    queue_instr(0,    0,    0,  1,  0,  1, 8'hFF, 8'hFF);
    queue_instr(4095, 0,    0,  1,  0,  0, 8'hFF, 8'h80);
    queue_instr(4095, 4095, 1,  3,  1,  1, 8'h00, 8'h01);
    queue_instr(0,    4095, 1,  15, 1,  1, 8'hFF, 8'hFF);
    queue_instr(0,    0,    15, 0,  15, 1, 8'h00, 8'hFF);
    queue_instr(4095, 4095, 1,  2,  0,  0, 8'hAA, 8'h55);
    // read-only flags hold zero
    queue_instr(1,    2,    0,  3,  0,  0, 8'hFF, 8'hFF);
    queue_instr(1,    2,    0,  4,  0,  0, 8'hFF, 8'hFF);
    queue_instr(1,    2,    0,  6,  0,  0, 8'hFF, 8'hFF);
    queue_instr(1,    2,    0,  7,  0,  0, 8'hFF, 8'hFF);
    queue_instr(3,    3,    3,  0,  3,  1, 8'hFF, 8'hFF);
    queue_instr(3,    3,    4,  0,  4,  1, 8'hFF, 8'hFF);
    queue_instr(3,    3,    6,  0,  6,  1, 8'hFF, 8'hFF);
    queue_instr(3,    3,    7,  0,  7,  1, 8'hFF, 8'hFF);
    queue_instr(3,    3,    0,  5,  0,  1, 8'hFF, 8'hFF);
    // writable flags, then gate on them both ways
    queue_instr(2048, 2047, 0,  8,  0,  0, 8'h5A, 8'hFF);
    queue_instr(2047, 2048, 8,  14, 8,  1, 8'hC3, 8'h3C);
    queue_instr(1365, 2730, 15, 12, 15, 0, 8'hFF, 8'hFF);
    queue_instr(2730, 1365, 14, 9,  15, 1, 8'h00, 8'h00);
    queue_instr(4095, 0,    1,  15, 1,  1, 8'h00, 8'h00);
    queue_instr(4095, 0,    15, 10, FLAG_LAST, 0, 8'hF0, 8'h0F);
    queue_instr(0,    4095, 13, 11, 2,  1, 8'h96, 8'h69);
    wait_drained();

    tx_idle_pct = 31;
    rx_idle_pct = 45;
    queue_random(PHASE_ITEMS);
    repeat (10) @(negedge clk_i);
    hold_requests++;
    wait_drained();

    tx_idle_pct = 45;
    rx_idle_pct = 31;
    queue_random(PHASE_ITEMS / 2);
    wait_drained();
    queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(PHASE_ITEMS);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (flag_expected.size() != 0)
      report_mismatch($sformatf("%0d flag results never arrived", flag_expected.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
